// ===== design/e2q_pkg.sv =====
`timescale 1ns / 1ps
package e2q_pkg;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
    } t_e2q_in;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } t_e2q_out;

    localparam int TAB_LEN = 24;
    localparam int HALF_FRAC = 14;
    localparam int Q30_FRAC = 30;
    localparam logic signed [17:0] ONE_Q14 = 18'sd16384;

    localparam logic [31:0] ATAN_Q30 [TAB_LEN] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
        32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
        32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };
    localparam logic [31:0] GAIN_Q30 = 32'h26DD3B6A;
    localparam logic [31:0] PI_Q30 = 32'hC90FDAA2;
    localparam logic [31:0] HALF_PI_Q30 = 32'h6487ED51;

    // round half up of a Q30 constant to nb fractional bits
    function automatic logic signed [39:0] q30_to(input logic [31:0] v, input int nb);
        logic signed [39:0] w;
        begin
            w = $signed({8'd0, v});
            q30_to = (w + (40'sd1 <<< (Q30_FRAC - nb - 1))) >>> (Q30_FRAC - nb);
        end
    endfunction

endpackage

// ===== design/e2q_cordic.sv =====
`timescale 1ns / 1ps
module e2q_cordic #(
    parameter int CORDIC_STAGES = 16,
    parameter int ANGLE_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [15:0]  i_angle,
    output logic signed [15:0]  o_cos,
    output logic signed [15:0]  o_sin
);
    import e2q_pkg::*;

    localparam int NST = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
    localparam int W = ANGLE_BITS + 4;
    localparam logic signed [W-1:0] PI_C = W'(q30_to(PI_Q30, ANGLE_BITS));
    localparam logic signed [W-1:0] HP_C = W'(q30_to(HALF_PI_Q30, ANGLE_BITS));
    localparam logic signed [W-1:0] GAIN_C = W'(q30_to(GAIN_Q30, ANGLE_BITS));

    logic signed [W-1:0] r_x [NST+1];
    logic signed [W-1:0] r_y [NST+1];
    logic signed [W-1:0] r_z [NST+1];
    logic                r_neg [NST+1];
    logic signed [W-1:0] w_z0;
    logic signed [15:0]  n_cos, n_sin;
    logic signed [15:0]  r_cos, r_sin;

    // half angle as Q.14 rescaled, rounding half up when fewer bits are kept
    if (ANGLE_BITS >= HALF_FRAC) begin : g_z_up
        assign w_z0 = W'(i_angle) <<< (ANGLE_BITS - HALF_FRAC);
    end else begin : g_z_dn
        assign w_z0 = W'((17'(i_angle) + (17'sd1 <<< (HALF_FRAC - ANGLE_BITS - 1)))
                         >>> (HALF_FRAC - ANGLE_BITS));
    end

    // fold into +-pi/2, then one rotation per stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= GAIN_C;
            r_y[0] <= '0;
            if (w_z0 > HP_C) begin
                r_z[0] <= w_z0 - PI_C;
                r_neg[0] <= 1'b1;
            end else if (w_z0 < -HP_C) begin
                r_z[0] <= w_z0 + PI_C;
                r_neg[0] <= 1'b1;
            end else begin
                r_z[0] <= w_z0;
                r_neg[0] <= 1'b0;
            end
            for (int i = 0; i < NST; i++) begin
                r_neg[i+1] <= r_neg[i];
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - W'(q30_to(ATAN_Q30[i], ANGLE_BITS));
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + W'(q30_to(ATAN_Q30[i], ANGLE_BITS));
                end
            end
        end
    end

    // sign fix, round to Q1.14 and clamp
    function automatic logic signed [15:0] fin(input logic signed [W-1:0] v, input logic ng);
        logic signed [W:0] t;
        logic signed [W:0] r;
        begin
            t = ng ? -(W+1)'(v) : (W+1)'(v);
            if (ANGLE_BITS > HALF_FRAC)
                r = (t + ((W+1)'(1) <<< (ANGLE_BITS - HALF_FRAC - 1)))
                    >>> (ANGLE_BITS - HALF_FRAC);
            else
                r = t <<< (HALF_FRAC - ANGLE_BITS);
            if (r > (W+1)'(ONE_Q14)) fin = 16'sd16384;
            else if (r < -(W+1)'(ONE_Q14)) fin = -16'sd16384;
            else fin = r[15:0];
        end
    endfunction

    always_comb begin
        n_cos = fin(r_x[NST], r_neg[NST]);
        n_sin = fin(r_y[NST], r_neg[NST]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= n_cos;
            r_sin <= n_sin;
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;
endmodule

// ===== design/e2q_merge.sv =====
`timescale 1ns / 1ps
module e2q_merge (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_cr, i_sr, i_cp, i_sp, i_cy, i_sy,
    output e2q_pkg::t_e2q_out  o_quat
);
    import e2q_pkg::*;

    logic signed [31:0] r_cc, r_ss, r_sc, r_cs;
    logic signed [15:0] r_cy, r_sy;
    logic signed [47:0] r_p [8];
    t_e2q_out           r_q;

    // stage one: roll times pitch
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cc <= i_cr * i_cp;
            r_ss <= i_sr * i_sp;
            r_sc <= i_sr * i_cp;
            r_cs <= i_cr * i_sp;
            r_cy <= i_cy;
            r_sy <= i_sy;
        end
    end

    // stage two: times yaw
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= r_cc * r_cy;
            r_p[1] <= r_ss * r_sy;
            r_p[2] <= r_sc * r_cy;
            r_p[3] <= r_cs * r_sy;
            r_p[4] <= r_cs * r_cy;
            r_p[5] <= r_sc * r_sy;
            r_p[6] <= r_cc * r_sy;
            r_p[7] <= r_ss * r_cy;
        end
    end

    function automatic logic signed [15:0] fin(input logic signed [48:0] v);
        logic signed [48:0] r;
        begin
            r = (v + 49'sd134217728) >>> 28;
            if (r > 49'sd16384) fin = 16'sd16384;
            else if (r < -49'sd16384) fin = -16'sd16384;
            else fin = r[15:0];
        end
    endfunction

    // stage three: sums, round and clamp
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q.quat_w <= fin(49'(r_p[0]) + 49'(r_p[1]));
            r_q.quat_x <= fin(49'(r_p[2]) - 49'(r_p[3]));
            r_q.quat_y <= fin(49'(r_p[4]) + 49'(r_p[5]));
            r_q.quat_z <= fin(49'(r_p[6]) - 49'(r_p[7]));
        end
    end

    assign o_quat = r_q;
endmodule

// ===== design/euler_to_quaternion.sv =====
`timescale 1ns / 1ps
// ZYX Euler angles (Q3.13 radians) to a clamped Q1.14 quaternion. Three CORDIC
// lanes, one per half angle, run in lockstep with a pipelined product merge. One
// transfer is taken every cycle unless the output is held; each result passes
// through the CORDIC stage chain and then the merge stages. The whole pipe stalls
// together when the output is held, so no result is dropped.
module euler_to_quaternion #(
    parameter int CORDIC_STAGES = 16,
    parameter int ANGLE_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  e2q_pkg::t_e2q_in   i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output e2q_pkg::t_e2q_out  o_data
);
    import e2q_pkg::*;

    localparam int NST = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
    localparam int LAT = NST + 5;

    logic             w_en;
    logic [LAT-1:0]   r_vld;
    logic signed [15:0] w_cr, w_sr, w_cp, w_sp, w_cy, w_sy;

    // pipe advances unless a finished result is held
    assign w_en = ~r_vld[LAT-1] | i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    e2q_cordic #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_BITS(ANGLE_BITS)) u_roll (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_data.roll_angle), .o_cos(w_cr), .o_sin(w_sr));
    e2q_cordic #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_BITS(ANGLE_BITS)) u_pitch (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_data.pitch_angle), .o_cos(w_cp), .o_sin(w_sp));
    e2q_cordic #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_BITS(ANGLE_BITS)) u_yaw (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_data.yaw_angle), .o_cos(w_cy), .o_sin(w_sy));

    e2q_merge u_merge (
        .i_clk(i_clk), .i_en(w_en),
        .i_cr(w_cr), .i_sr(w_sr), .i_cp(w_cp), .i_sp(w_sp), .i_cy(w_cy), .i_sy(w_sy),
        .o_quat(o_data));

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("held result changed");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("stalled with empty output");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.quat_w <= 16'sd16384 && o_data.quat_w >= -16'sd16384)
        else $error("w out of range");
`endif
endmodule

// ===== tb/sv/tb_euler_to_quaternion.sv =====
`timescale 1ns / 1ps
module tb_euler_to_quaternion;
    import e2q_pkg::*;

    localparam int STAGES = 16;
    localparam int ABITS = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam longint UNIT = 16384;
    // pi in the input's Q3.13 format, where the half angle crosses pi/2
    localparam int PI_Q13 = 25736;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_e2q_in i_data;
    logic o_valid;
    logic i_ready;
    t_e2q_out o_data;

    t_e2q_out quat_queue[$];
    int mismatch_count;
    bit tx_idle;
    bit rx_idle;
    int rx_hold_req;
    int stall_cycles;

    euler_to_quaternion #(
        .CORDIC_STAGES(STAGES),
        .ANGLE_BITS(ABITS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data(i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data(o_data)
    );

    // clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // round half up of v / 2^s, floor shifts throughout
    function automatic longint round_shr(input longint v, input int s);
        if (s <= 0) return v;
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint requant(input longint v, input int from, input int to);
        if (to >= from) return v <<< (to - from);
        return round_shr(v, from - to);
    endfunction

    function automatic longint sat_unit(input longint v);
        if (v > UNIT) return UNIT;
        if (v < -UNIT) return -UNIT;
        return v;
    endfunction

    // cosine and sine of a half angle given in Q.14
    task automatic half_trig(input longint h14, output longint c, output longint s);
        longint z, x, y, dx, dy, a, pi_v, hp_v;
        bit flip;
        z = requant(h14, HALF_FRAC, ABITS);
        pi_v = requant(longint'(PI_Q30), Q30_FRAC, ABITS);
        hp_v = requant(longint'(HALF_PI_Q30), Q30_FRAC, ABITS);
        x = requant(longint'(GAIN_Q30), Q30_FRAC, ABITS);
        y = 0;
        flip = 1'b0;
        if (z > hp_v) begin
            z -= pi_v;
            flip = 1'b1;
        end else if (z < -hp_v) begin
            z += pi_v;
            flip = 1'b1;
        end
        for (int i = 0; i < STAGES && i < TAB_LEN; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            a = requant(longint'(ATAN_Q30[i]), Q30_FRAC, ABITS);
            if (z >= 0) begin
                x -= dx; y += dy; z -= a;
            end else begin
                x += dx; y -= dy; z += a;
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = sat_unit(requant(x, ABITS, HALF_FRAC));
        s = sat_unit(requant(y, ABITS, HALF_FRAC));
    endtask

    function automatic logic signed [15:0] to_q14(input longint sum42);
        longint r;
        r = sat_unit(round_shr(sum42, 2 * HALF_FRAC));
        return r[15:0];
    endfunction

    // zyx combination of the three half-angle rotations
    task automatic predict_quat(input t_e2q_in a, output t_e2q_out q);
        longint cr, sr, cp, sp, cy, sy;
        half_trig(longint'(a.roll_angle), cr, sr);
        half_trig(longint'(a.pitch_angle), cp, sp);
        half_trig(longint'(a.yaw_angle), cy, sy);
        q.quat_w = to_q14(cr * cp * cy + sr * sp * sy);
        q.quat_x = to_q14(sr * cp * cy - cr * sp * sy);
        q.quat_y = to_q14(cr * sp * cy + sr * cp * sy);
        q.quat_z = to_q14(cr * cp * sy - sr * sp * cy);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // send one angle triple, leaving valid high after the transfer
    task automatic send_angles(input t_e2q_in a);
        int gap;
        t_e2q_out q;
        gap = tx_idle ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= a;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        predict_quat(a, q);
        quat_queue.push_back(q);
    endtask

    task automatic send_rpy(input int r, input int p, input int y);
        t_e2q_in a;
        a.roll_angle = r[15:0];
        a.pitch_angle = p[15:0];
        a.yaw_angle = y[15:0];
        send_angles(a);
    endtask

    // mostly raw bits, some near the wrap point of the half angle
    function automatic int pick_angle();
        if ($urandom_range(0, 7) == 0)
            return ($urandom_range(0, 1) ? PI_Q13 : -PI_Q13) + $urandom_range(0, 8) - 4;
        return int'($urandom_range(0, 65535));
    endfunction

    task automatic send_random(input int n);
        repeat (n) send_rpy(pick_angle(), pick_angle(), pick_angle());
    endtask

    // drop valid right at the last transfer edge, then wait for all results
    task automatic wait_drained();
        i_valid <= 1'b0;
        wait (quat_queue.size() == 0);
    endtask

    task automatic test_directed();
        int edges[8] = '{0, 32767, -32768, 1, -1, PI_Q13 - 1, PI_Q13, -PI_Q13};
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        foreach (edges[i]) send_rpy(edges[i], edges[i], edges[i]);
        send_rpy(12868, 0, 0);
        send_rpy(0, 12868, 0);
        send_rpy(0, 0, 12868);
        send_rpy(32767, -32768, 0);
        send_rpy(-32768, 32767, 32767);
        send_rpy(PI_Q13 + 1, -PI_Q13 - 1, PI_Q13 + 1);
        send_rpy(-12868, 25735, -25737);
        send_rpy(4096, 8192, -4096);
        wait_drained();
    endtask

    task automatic test_random_idling();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_random(1000);
        wait_drained();
    endtask

    task automatic test_back_to_back();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_random(300);
        rx_idle = 1'b1;
        send_random(150);
        tx_idle = 1'b1;
        rx_idle = 1'b0;
        send_random(150);
        wait_drained();
    endtask

    // receiver holds off long enough for the pipe to fill and stall its input
    task automatic test_backpressure();
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        rx_hold_req = 300;
        send_random(200);
        // pause until every result is out, then resume
        wait_drained();
        send_random(50);
        wait_drained();
    endtask

    // receiver ready, with random holds per transfer
    initial begin
        int gap;
        i_ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = rx_idle ? $urandom_range(0, 18) : 0;
            if (rx_hold_req > 0) begin
                gap = rx_hold_req;
                rx_hold_req = 0;
            end
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
        end
    end

    // result check on each output transfer
    always @(posedge i_clk) begin
        t_e2q_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (quat_queue.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                want = quat_queue.pop_front();
                if (o_data.quat_w !== want.quat_w)
                    report_mismatch("quat_w", o_data.quat_w, want.quat_w);
                if (o_data.quat_x !== want.quat_x)
                    report_mismatch("quat_x", o_data.quat_x, want.quat_x);
                if (o_data.quat_y !== want.quat_y)
                    report_mismatch("quat_y", o_data.quat_y, want.quat_y);
                if (o_data.quat_z !== want.quat_z)
                    report_mismatch("quat_z", o_data.quat_z, want.quat_z);
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data <= '0;
        mismatch_count = 0;
        rx_hold_req = 0;
        stall_cycles = 0;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_idling();
        test_back_to_back();
        test_backpressure();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && quat_queue.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
design/e2q_pkg.sv
design/e2q_cordic.sv
design/e2q_merge.sv
design/euler_to_quaternion.sv
tb/sv/tb_euler_to_quaternion.sv
